FILE: rtl/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared constants and types for the text console writer: screen geometry,
// field widths, operation codes, register indexes and the cell layout.
// ----------------------------------------------------------------------------
`default_nettype none

package tcw_pkg;

  localparam int SCREEN_COLS = 80;
  localparam int SCREEN_ROWS = 25;
  localparam int TAB_STOP    = 8;   // power of two: tab phase is a mask
  localparam int CELL_COUNT  = SCREEN_COLS * SCREEN_ROWS;

  localparam int COL_W   = 7;
  localparam int ROW_W   = 5;
  localparam int OFF_W   = 11;
  localparam int BYTE_W  = 8;
  localparam int MODE_W  = 3;
  localparam int CFG_W   = 8;
  localparam int CFG_IDX_W = 1;
  localparam int ADDR_W  = $clog2(CELL_COUNT);
  localparam int CNT_W   = $clog2(CELL_COUNT + 1);
  localparam int STEP_W  = $clog2(SCREEN_COLS + 1);

  localparam logic [MODE_W-1:0] MODE_PUT_CHAR   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_SET_CURSOR = 3'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR      = 3'd2;
  localparam logic [MODE_W-1:0] MODE_WRITE_CELL = 3'd3;
  localparam logic [MODE_W-1:0] MODE_READ_CELL  = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_CURSOR_IN_BUFFER = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_ATTR     = 1'b1;

  localparam logic [BYTE_W-1:0] MARK_CHAR  = 8'h5F;
  localparam logic [BYTE_W-1:0] BLANK_CHAR = 8'h20;
  localparam logic [BYTE_W-1:0] CHAR_LF    = 8'h0A;
  localparam logic [BYTE_W-1:0] CHAR_TAB   = 8'h09;
  localparam logic [BYTE_W-1:0] MARK_ATTR  = 8'h00;

  typedef struct packed {
    logic [BYTE_W-1:0] chr;
    logic [BYTE_W-1:0] attr;
  } cell_t;

endpackage

`default_nettype wire

FILE: rtl/text_console_writer_unit.sv
// Put char without scroll, write cell, read cell and unused modes go from S_IDLE through
//   S_FINISH to the result; set cursor with the marker off goes through S_MARK, then S_FINISH,
//   which waits while a stalled result is offered. A new item is taken only back in S_IDLE.
// Marker on: set cursor scans up from cell 0 for the old marker and blanks the first one found.
//   Scroll copies every row up one row, then blanks the bottom row; clear screen blanks the whole store.
// Reset: a clearing pass zeroes every cell of the store; items stall meanwhile.
// ----------------------------------------------------------------------------
// text_console_writer_unit
// Teletype-style text console: a cell store in one synchronous RAM, a print
// position, newline/tab/scroll handling and an optional in-store marker.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_writer_unit (
  input  wire                            clk,
  input  wire                            rst,
  input  wire                            item_valid,
  output logic                           item_stall,
  input  wire  [tcw_pkg::MODE_W-1:0]     mode,
  input  wire  [tcw_pkg::BYTE_W-1:0]     char_code,
  input  wire  [tcw_pkg::COL_W-1:0]      col,
  input  wire  [tcw_pkg::ROW_W-1:0]      row,
  output logic                           result_valid,
  input  wire                            result_stall,
  output logic [tcw_pkg::OFF_W-1:0]      cursor_offset,
  output logic [tcw_pkg::COL_W-1:0]      cursor_col,
  output logic [tcw_pkg::ROW_W-1:0]      cursor_row,
  output logic [tcw_pkg::BYTE_W-1:0]     read_char,
  output logic [tcw_pkg::BYTE_W-1:0]     read_attr,
  input  wire                            cfg_we,
  input  wire  [tcw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire  [tcw_pkg::CFG_W-1:0]      cfg_data
);

  typedef enum logic [2:0] {
    S_FILL, S_IDLE, S_SCAN, S_MARK, S_SCROLL, S_FINISH
  } state_t;

  state_t state;

  // configuration
  logic                         cursor_in_buffer;
  logic [tcw_pkg::BYTE_W-1:0]   default_attribute;

  // print position, kept as offset plus col/row so no division is needed
  logic [tcw_pkg::OFF_W-1:0]    print_offset;
  logic [tcw_pkg::COL_W-1:0]    print_col;
  logic [tcw_pkg::ROW_W-1:0]    print_row;

  // latched operation
  logic [tcw_pkg::MODE_W-1:0]   op_mode;
  logic [tcw_pkg::OFF_W-1:0]    op_lin;
  logic [tcw_pkg::COL_W-1:0]    op_x;
  logic [tcw_pkg::ROW_W-1:0]    op_y;

  logic                         initing;
  logic [tcw_pkg::CNT_W-1:0]    fill_addr;
  logic [tcw_pkg::CNT_W-1:0]    scan_addr;
  logic [tcw_pkg::ADDR_W-1:0]   scan_last;
  logic                         scan_pend;
  logic [tcw_pkg::CNT_W-1:0]    cp_src;
  logic [tcw_pkg::ADDR_W-1:0]   cp_last;
  logic                         cp_pend;

  // cell store
  tcw_pkg::cell_t               mem [tcw_pkg::CELL_COUNT];
  tcw_pkg::cell_t               rd_data;
  logic                         mem_we;
  logic [tcw_pkg::ADDR_W-1:0]   mem_waddr;
  tcw_pkg::cell_t               mem_wdata;
  logic                         mem_re;
  logic [tcw_pkg::ADDR_W-1:0]   mem_raddr;

  logic                         accept;
  logic [tcw_pkg::COL_W-1:0]    x_cl;
  logic [tcw_pkg::ROW_W-1:0]    y_cl;
  logic [tcw_pkg::OFF_W-1:0]    lin_in;
  logic                         is_ordinary;
  logic [tcw_pkg::STEP_W-1:0]   step;
  logic [tcw_pkg::OFF_W:0]      off_sum;
  logic [tcw_pkg::COL_W:0]      col_sum;
  logic                         col_wrap;
  logic                         mark_hit;
  logic                         out_free;
  tcw_pkg::cell_t               blank_cell;

  assign item_stall = (state != S_IDLE);
  assign accept     = item_valid && !item_stall;
  assign out_free   = !result_valid || !result_stall;
  assign blank_cell = '{chr: tcw_pkg::BLANK_CHAR, attr: default_attribute};
  assign mark_hit   = (rd_data.chr == tcw_pkg::MARK_CHAR) && (rd_data.attr == tcw_pkg::MARK_ATTR);

  assign x_cl   = (col >= tcw_pkg::COL_W'(tcw_pkg::SCREEN_COLS))
                  ? tcw_pkg::COL_W'(tcw_pkg::SCREEN_COLS - 1) : col;
  assign y_cl   = (row >= tcw_pkg::ROW_W'(tcw_pkg::SCREEN_ROWS))
                  ? tcw_pkg::ROW_W'(tcw_pkg::SCREEN_ROWS - 1) : row;
  assign lin_in = tcw_pkg::OFF_W'(y_cl) * tcw_pkg::OFF_W'(tcw_pkg::SCREEN_COLS)
                  + tcw_pkg::OFF_W'(x_cl);

  // put char: distance to the next print position
  assign is_ordinary = (char_code != tcw_pkg::CHAR_LF) && (char_code != tcw_pkg::CHAR_TAB);

  always_comb begin
    if (char_code == tcw_pkg::CHAR_LF) begin
      step = tcw_pkg::STEP_W'(tcw_pkg::SCREEN_COLS) - tcw_pkg::STEP_W'(print_col);
    end else if (char_code == tcw_pkg::CHAR_TAB) begin
      step = tcw_pkg::STEP_W'(tcw_pkg::TAB_STOP)
             - tcw_pkg::STEP_W'(print_offset % tcw_pkg::TAB_STOP);
    end else begin
      step = tcw_pkg::STEP_W'(1);
    end
  end

  assign off_sum  = {1'b0, print_offset} + (tcw_pkg::OFF_W + 1)'(step);
  assign col_sum  = {1'b0, print_col} + (tcw_pkg::COL_W + 1)'(step);
  assign col_wrap = (col_sum >= (tcw_pkg::COL_W + 1)'(tcw_pkg::SCREEN_COLS));

  // store port control
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = '0;
    case (state)
      S_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = fill_addr[tcw_pkg::ADDR_W-1:0];
        mem_wdata = initing ? tcw_pkg::cell_t'('0) : blank_cell;
      end
      S_IDLE: begin
        if (accept) begin
          case (mode)
            tcw_pkg::MODE_PUT_CHAR: begin
              mem_we    = is_ordinary;
              mem_waddr = tcw_pkg::ADDR_W'(print_offset);
              mem_wdata = '{chr: char_code, attr: default_attribute};
            end
            tcw_pkg::MODE_WRITE_CELL: begin
              mem_we    = 1'b1;
              mem_waddr = tcw_pkg::ADDR_W'(lin_in);
              mem_wdata = '{chr: char_code, attr: default_attribute};
            end
            tcw_pkg::MODE_READ_CELL: begin
              mem_re    = 1'b1;
              mem_raddr = tcw_pkg::ADDR_W'(lin_in);
            end
            default: begin
            end
          endcase
        end
      end
      S_SCAN: begin
        if (scan_pend && mark_hit) begin
          mem_we    = 1'b1;
          mem_waddr = scan_last;
          mem_wdata = blank_cell;
        end else if (scan_addr != tcw_pkg::CNT_W'(tcw_pkg::CELL_COUNT)) begin
          mem_re    = 1'b1;
          mem_raddr = scan_addr[tcw_pkg::ADDR_W-1:0];
        end
      end
      S_MARK: begin
        mem_we    = cursor_in_buffer;
        mem_waddr = tcw_pkg::ADDR_W'(op_lin);
        mem_wdata = '{chr: tcw_pkg::MARK_CHAR, attr: tcw_pkg::MARK_ATTR};
      end
      S_SCROLL: begin
        // read a row below, write one row up; source stays ahead of writes
        if (cp_pend) begin
          mem_we    = 1'b1;
          mem_waddr = cp_last - tcw_pkg::ADDR_W'(tcw_pkg::SCREEN_COLS);
          mem_wdata = rd_data;
        end
        if (cp_src != tcw_pkg::CNT_W'(tcw_pkg::CELL_COUNT)) begin
          mem_re    = 1'b1;
          mem_raddr = cp_src[tcw_pkg::ADDR_W-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_in_buffer  <= 1'b1;
      default_attribute <= 8'd7;
    end else if (cfg_we) begin
      case (cfg_index)
        tcw_pkg::REG_CURSOR_IN_BUFFER: cursor_in_buffer  <= cfg_data[0];
        tcw_pkg::REG_DEFAULT_ATTR:     default_attribute <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_FILL;
      initing      <= 1'b1;
      fill_addr    <= '0;
      print_offset <= '0;
      print_col    <= '0;
      print_row    <= '0;
      result_valid <= 1'b0;
      scan_pend    <= 1'b0;
      cp_pend      <= 1'b0;
      scan_addr    <= '0;
      cp_src       <= '0;
    end else begin
      // S_FINISH raises the result itself
      if (result_valid && !result_stall && (state != S_FINISH)) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_FILL: begin
          fill_addr <= fill_addr + 1'b1;
          if (fill_addr == tcw_pkg::CNT_W'(tcw_pkg::CELL_COUNT - 1)) begin
            if (initing) begin
              initing <= 1'b0;
              state   <= S_IDLE;
            end else if (op_mode == tcw_pkg::MODE_CLEAR) begin
              state <= S_MARK;
            end else begin
              state <= S_FINISH;
            end
          end
        end
        S_IDLE: begin
          if (accept) begin
            op_mode <= mode;
            // clear screen homes the cursor
            op_lin  <= (mode == tcw_pkg::MODE_CLEAR) ? '0 : lin_in;
            op_x    <= (mode == tcw_pkg::MODE_CLEAR) ? '0 : x_cl;
            op_y    <= (mode == tcw_pkg::MODE_CLEAR) ? '0 : y_cl;
            case (mode)
              tcw_pkg::MODE_PUT_CHAR: begin
                if (off_sum >= (tcw_pkg::OFF_W + 1)'(tcw_pkg::CELL_COUNT)) begin
                  print_offset <= tcw_pkg::OFF_W'(tcw_pkg::CELL_COUNT - tcw_pkg::SCREEN_COLS);
                  print_col    <= '0;
                  print_row    <= tcw_pkg::ROW_W'(tcw_pkg::SCREEN_ROWS - 1);
                  cp_src       <= tcw_pkg::CNT_W'(tcw_pkg::SCREEN_COLS);
                  cp_pend      <= 1'b0;
                  state        <= S_SCROLL;
                end else begin
                  print_offset <= off_sum[tcw_pkg::OFF_W-1:0];
                  print_col    <= col_wrap
                                  ? tcw_pkg::COL_W'(col_sum - (tcw_pkg::COL_W + 1)'(tcw_pkg::SCREEN_COLS))
                                  : col_sum[tcw_pkg::COL_W-1:0];
                  print_row    <= print_row + tcw_pkg::ROW_W'(col_wrap);
                  state        <= S_FINISH;
                end
              end
              tcw_pkg::MODE_SET_CURSOR: begin
                scan_addr <= '0;
                scan_pend <= 1'b0;
                state     <= cursor_in_buffer ? S_SCAN : S_MARK;
              end
              tcw_pkg::MODE_CLEAR: begin
                // whole store goes blank, so no old marker is left to erase
                fill_addr <= '0;
                state     <= S_FILL;
              end
              default: begin
                state <= S_FINISH;
              end
            endcase
          end
        end
        S_SCAN: begin
          if (scan_pend && mark_hit) begin
            scan_pend <= 1'b0;
            state     <= S_MARK;
          end else if (scan_addr == tcw_pkg::CNT_W'(tcw_pkg::CELL_COUNT)) begin
            scan_pend <= 1'b0;
            state     <= S_MARK;
          end else begin
            scan_pend <= 1'b1;
            scan_last <= scan_addr[tcw_pkg::ADDR_W-1:0];
            scan_addr <= scan_addr + 1'b1;
          end
        end
        S_MARK: begin
          print_offset <= op_lin;
          print_col    <= op_x;
          print_row    <= op_y;
          state        <= S_FINISH;
        end
        S_SCROLL: begin
          if (cp_src != tcw_pkg::CNT_W'(tcw_pkg::CELL_COUNT)) begin
            cp_pend <= 1'b1;
            cp_last <= cp_src[tcw_pkg::ADDR_W-1:0];
            cp_src  <= cp_src + 1'b1;
          end else if (cp_pend) begin
            cp_pend <= 1'b0;
          end else begin
            fill_addr <= tcw_pkg::CNT_W'(tcw_pkg::CELL_COUNT - tcw_pkg::SCREEN_COLS);
            state     <= S_FILL;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            result_valid  <= 1'b1;
            cursor_offset <= print_offset;
            cursor_col    <= print_col;
            cursor_row    <= print_row;
            if (op_mode == tcw_pkg::MODE_READ_CELL) begin
              read_char <= rd_data.chr;
              read_attr <= rd_data.attr;
            end else begin
              read_char <= '0;
              read_attr <= '0;
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: rtl/tcw_checker.sv
// ----------------------------------------------------------------------------
// tcw_checker
// Port-level checks on the text console writer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_checker (
  input wire                            clk,
  input wire                            rst,
  input wire                            result_valid,
  input wire                            result_stall,
  input wire [tcw_pkg::OFF_W-1:0]       cursor_offset,
  input wire [tcw_pkg::COL_W-1:0]       cursor_col,
  input wire [tcw_pkg::ROW_W-1:0]       cursor_row
);

  // a stalled result stays offered
  a_result_held: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid)
    else $error("result dropped while stalled");

  // no result straight out of reset
  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> !result_valid)
    else $error("result valid after reset");

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (cursor_col < tcw_pkg::COL_W'(tcw_pkg::SCREEN_COLS))
                  && (cursor_row < tcw_pkg::ROW_W'(tcw_pkg::SCREEN_ROWS)))
    else $error("cursor position out of range");

  // offset, column and row describe the same place
  a_pos_consistent: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> cursor_offset ==
      tcw_pkg::OFF_W'(cursor_row) * tcw_pkg::OFF_W'(tcw_pkg::SCREEN_COLS)
      + tcw_pkg::OFF_W'(cursor_col))
    else $error("cursor offset disagrees with column and row");

endmodule

bind text_console_writer_unit tcw_checker u_tcw_checker (
  .clk           (clk),
  .rst           (rst),
  .result_valid  (result_valid),
  .result_stall  (result_stall),
  .cursor_offset (cursor_offset),
  .cursor_col    (cursor_col),
  .cursor_row    (cursor_row)
);

`default_nettype wire

FILE: tb/tb_text_console_writer_unit.sv
`timescale 1ns / 100ps

// ----------------------------------------------------------------------------
// tb_text_console_writer_unit
// Self-checking bench for the text console writer. A short directed run covers
// clamping, tab, newline, scrolling, the in-store marker and the spare modes.
// Random console traffic then runs under several register settings and stall
// patterns. Every result transfer is checked against a behavioural screen
// model kept in the scoreboard.
// ----------------------------------------------------------------------------
module tb_text_console_writer_unit;

  // the limit allows for the worst item, roughly a full store walk plus stalls,
  // on every one of ~1.8k items, with the reset clearing pass, about three times over
  localparam int LIMIT       = 12_000_000;
  localparam int SETTLE      = tcw_pkg::CELL_COUNT + 16;
  localparam int PHASE_ITEMS = 290;
  localparam int PHASES      = 6;

  localparam logic [tcw_pkg::MODE_W-1:0] MODE_SPARE_LO = 3'd5;
  localparam logic [tcw_pkg::MODE_W-1:0] MODE_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [tcw_pkg::OFF_W-1:0]  off;
    logic [tcw_pkg::COL_W-1:0]  c;
    logic [tcw_pkg::ROW_W-1:0]  r;
    logic [tcw_pkg::BYTE_W-1:0] rd_chr;
    logic [tcw_pkg::BYTE_W-1:0] rd_attr;
  } console_view_t;

  class console_scoreboard;
    logic [tcw_pkg::BYTE_W-1:0] chr_mem  [tcw_pkg::CELL_COUNT];
    logic [tcw_pkg::BYTE_W-1:0] attr_mem [tcw_pkg::CELL_COUNT];
    int                         pos;
    bit                         marker_on;
    logic [tcw_pkg::BYTE_W-1:0] fill_attr;
    console_view_t              view_q[$];
    int                         mismatches;

    function new();
      for (int i = 0; i < tcw_pkg::CELL_COUNT; i++) begin
        chr_mem[i]  = '0;
        attr_mem[i] = '0;
      end
      pos        = 0;
      marker_on  = 1'b1;
      fill_attr  = 8'd7;
      mismatches = 0;
    endfunction

    function void write_reg(logic [tcw_pkg::CFG_IDX_W-1:0] idx,
                            logic [tcw_pkg::CFG_W-1:0] val);
      case (idx)
        tcw_pkg::REG_CURSOR_IN_BUFFER: marker_on = val[0];
        tcw_pkg::REG_DEFAULT_ATTR:     fill_attr = val;
        default: ;
      endcase
    endfunction

    function void blank_cell(int i);
      chr_mem[i]  = tcw_pkg::BLANK_CHAR;
      attr_mem[i] = fill_attr;
    endfunction

    // only the lowest old marker goes, then the new one is drawn
    function void place_cursor(int lin);
      bit found;
      found = 1'b0;
      if (marker_on) begin
        for (int i = 0; i < tcw_pkg::CELL_COUNT && !found; i++) begin
          if (chr_mem[i] == tcw_pkg::MARK_CHAR && attr_mem[i] == tcw_pkg::MARK_ATTR) begin
            blank_cell(i);
            found = 1'b1;
          end
        end
        chr_mem[lin]  = tcw_pkg::MARK_CHAR;
        attr_mem[lin] = tcw_pkg::MARK_ATTR;
      end
      pos = lin;
    endfunction

    function void print_byte(logic [tcw_pkg::BYTE_W-1:0] ch);
      int nxt;
      nxt = pos;
      if (ch == tcw_pkg::CHAR_LF) begin
        nxt += tcw_pkg::SCREEN_COLS - (nxt % tcw_pkg::SCREEN_COLS);
      end else if (ch == tcw_pkg::CHAR_TAB) begin
        nxt += tcw_pkg::TAB_STOP - (nxt % tcw_pkg::TAB_STOP);
      end else begin
        chr_mem[nxt]  = ch;
        attr_mem[nxt] = fill_attr;
        nxt++;
      end
      if (nxt >= tcw_pkg::CELL_COUNT) begin
        for (int j = 0; j < tcw_pkg::CELL_COUNT - tcw_pkg::SCREEN_COLS; j++) begin
          chr_mem[j]  = chr_mem[j + tcw_pkg::SCREEN_COLS];
          attr_mem[j] = attr_mem[j + tcw_pkg::SCREEN_COLS];
        end
        for (int j = tcw_pkg::CELL_COUNT - tcw_pkg::SCREEN_COLS; j < tcw_pkg::CELL_COUNT; j++)
          blank_cell(j);
        nxt = tcw_pkg::CELL_COUNT - tcw_pkg::SCREEN_COLS;
      end
      pos = nxt;
    endfunction

    function void note_item(logic [tcw_pkg::MODE_W-1:0] m, logic [tcw_pkg::BYTE_W-1:0] ch,
                            logic [tcw_pkg::COL_W-1:0] x_in,
                            logic [tcw_pkg::ROW_W-1:0] y_in);
      int            x;
      int            y;
      int            lin;
      console_view_t v;
      x   = (x_in >= tcw_pkg::SCREEN_COLS) ? tcw_pkg::SCREEN_COLS - 1 : int'(x_in);
      y   = (y_in >= tcw_pkg::SCREEN_ROWS) ? tcw_pkg::SCREEN_ROWS - 1 : int'(y_in);
      lin = y * tcw_pkg::SCREEN_COLS + x;
      v.rd_chr  = '0;
      v.rd_attr = '0;
      case (m)
        tcw_pkg::MODE_PUT_CHAR:   print_byte(ch);
        tcw_pkg::MODE_SET_CURSOR: place_cursor(lin);
        tcw_pkg::MODE_CLEAR: begin
          for (int i = 0; i < tcw_pkg::CELL_COUNT; i++) blank_cell(i);
          place_cursor(0);
        end
        tcw_pkg::MODE_WRITE_CELL: begin
          chr_mem[lin]  = ch;
          attr_mem[lin] = fill_attr;
        end
        tcw_pkg::MODE_READ_CELL: begin
          v.rd_chr  = chr_mem[lin];
          v.rd_attr = attr_mem[lin];
        end
        default: ;
      endcase
      v.off = tcw_pkg::OFF_W'(pos);
      v.c   = tcw_pkg::COL_W'(pos % tcw_pkg::SCREEN_COLS);
      v.r   = tcw_pkg::ROW_W'(pos / tcw_pkg::SCREEN_COLS);
      view_q.push_back(v);
    endfunction

    function void check_result(console_view_t got);
      console_view_t want;
      if (view_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result transfer: off %0d col %0d row %0d chr %02h attr %02h",
                   got.off, got.c, got.r, got.rd_chr, got.rd_attr);
        return;
      end
      want = view_q.pop_front();
      if (got.off !== want.off || got.c !== want.c || got.r !== want.r ||
          got.rd_chr !== want.rd_chr || got.rd_attr !== want.rd_attr) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"mismatch: exp off %0d col %0d row %0d chr %02h attr %02h",
                    " / got off %0d col %0d row %0d chr %02h attr %02h"},
                   want.off, want.c, want.r, want.rd_chr, want.rd_attr,
                   got.off, got.c, got.r, got.rd_chr, got.rd_attr);
      end
    endfunction

    function int pending();
      return view_q.size();
    endfunction
  endclass

  logic                          clk = 1'b0;
  logic                          rst;
  logic                          item_valid;
  logic                          item_stall;
  logic [tcw_pkg::MODE_W-1:0]    mode;
  logic [tcw_pkg::BYTE_W-1:0]    char_code;
  logic [tcw_pkg::COL_W-1:0]     col;
  logic [tcw_pkg::ROW_W-1:0]     row;
  logic                          result_valid;
  logic                          result_stall;
  logic [tcw_pkg::OFF_W-1:0]     cursor_offset;
  logic [tcw_pkg::COL_W-1:0]     cursor_col;
  logic [tcw_pkg::ROW_W-1:0]     cursor_row;
  logic [tcw_pkg::BYTE_W-1:0]    read_char;
  logic [tcw_pkg::BYTE_W-1:0]    read_attr;
  logic                          cfg_we;
  logic [tcw_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [tcw_pkg::CFG_W-1:0]     cfg_data;

  int send_idle_pct = 18;
  int recv_idle_pct = 78;

  console_scoreboard sb;

  text_console_writer_unit u_top (
    .clk           (clk),
    .rst           (rst),
    .item_valid    (item_valid),
    .item_stall    (item_stall),
    .mode          (mode),
    .char_code     (char_code),
    .col           (col),
    .row           (row),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .cursor_offset (cursor_offset),
    .cursor_col    (cursor_col),
    .cursor_row    (cursor_row),
    .read_char     (read_char),
    .read_attr     (read_attr),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // result side: sample the pre-edge values, then pick this cycle's stall
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall)
      sb.check_result({cursor_offset, cursor_col, cursor_row, read_char, read_attr});
    result_stall <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  task automatic send_item(logic [tcw_pkg::MODE_W-1:0] m, logic [tcw_pkg::BYTE_W-1:0] ch,
                           logic [tcw_pkg::COL_W-1:0] x, logic [tcw_pkg::ROW_W-1:0] y);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    mode       <= m;
    char_code  <= ch;
    col        <= x;
    row        <= y;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    sb.note_item(m, ch, x, y);
  endtask

  task automatic write_regs(bit marker, logic [tcw_pkg::BYTE_W-1:0] attr);
    logic [tcw_pkg::CFG_W-1:0] marker_word;
    // upper bits are don't-care for the one-bit register
    marker_word = {7'($urandom_range(0, 127)), marker};
    cfg_we    <= 1'b1;
    cfg_index <= tcw_pkg::REG_CURSOR_IN_BUFFER;
    cfg_data  <= marker_word;
    @(posedge clk);
    sb.write_reg(tcw_pkg::REG_CURSOR_IN_BUFFER, marker_word);
    cfg_index <= tcw_pkg::REG_DEFAULT_ATTR;
    cfg_data  <= attr;
    @(posedge clk);
    sb.write_reg(tcw_pkg::REG_DEFAULT_ATTR, attr);
    cfg_we <= 1'b0;
  endtask

  // hold the sender until every expected transfer is back
  task automatic drain(bit settle);
    item_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    if (settle) repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic [tcw_pkg::BYTE_W-1:0] rand_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8)  return tcw_pkg::MARK_CHAR;
    if (r < 13) return tcw_pkg::CHAR_LF;
    if (r < 18) return tcw_pkg::CHAR_TAB;
    if (r < 21) return tcw_pkg::BLANK_CHAR;
    return tcw_pkg::BYTE_W'($urandom_range(0, 255));
  endfunction

  function automatic logic [tcw_pkg::COL_W-1:0] rand_col();
    if ($urandom_range(0, 9) == 0)
      return tcw_pkg::COL_W'($urandom_range(tcw_pkg::SCREEN_COLS, 127));
    return tcw_pkg::COL_W'($urandom_range(0, tcw_pkg::SCREEN_COLS - 1));
  endfunction

  function automatic logic [tcw_pkg::ROW_W-1:0] rand_row();
    if ($urandom_range(0, 9) == 0)
      return tcw_pkg::ROW_W'($urandom_range(tcw_pkg::SCREEN_ROWS, 31));
    return tcw_pkg::ROW_W'($urandom_range(0, tcw_pkg::SCREEN_ROWS - 1));
  endfunction

  // scans, scrolls and clears are long, so they are kept fairly rare
  task automatic send_random_item();
    int                         r;
    logic [tcw_pkg::MODE_W-1:0] m;
    r = $urandom_range(0, 999);
    if (r < 500)      m = tcw_pkg::MODE_PUT_CHAR;
    else if (r < 560) m = tcw_pkg::MODE_SET_CURSOR;
    else if (r < 565) m = tcw_pkg::MODE_CLEAR;
    else if (r < 725) m = tcw_pkg::MODE_WRITE_CELL;
    else if (r < 975) m = tcw_pkg::MODE_READ_CELL;
    else              m = tcw_pkg::MODE_W'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI));
    send_item(m, rand_char(), rand_col(), rand_row());
  endtask

  initial begin
    repeat (LIMIT) @(posedge clk);
    $display("FAIL");
    $finish;
  end

  initial begin
    sb = new();
    rst          <= 1'b1;
    item_valid   <= 1'b0;
    mode         <= tcw_pkg::MODE_PUT_CHAR;
    char_code    <= '0;
    col          <= '0;
    row          <= '0;
    cfg_we       <= 1'b0;
    cfg_index    <= tcw_pkg::REG_CURSOR_IN_BUFFER;
    cfg_data     <= '0;
    result_stall <= 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    write_regs(1'b1, 8'd7);

    // directed corners
    send_item(tcw_pkg::MODE_READ_CELL, 8'h00, 7'd0, 5'd0);
    send_item(tcw_pkg::MODE_READ_CELL, 8'h00, 7'd127, 5'd31);
    send_item(tcw_pkg::MODE_PUT_CHAR, 8'h00, 7'd0, 5'd0);
    send_item(tcw_pkg::MODE_PUT_CHAR, 8'hFF, 7'd127, 5'd31);
    send_item(tcw_pkg::MODE_PUT_CHAR, tcw_pkg::CHAR_TAB, 7'd0, 5'd0);
    send_item(tcw_pkg::MODE_PUT_CHAR, tcw_pkg::CHAR_LF, 7'd0, 5'd0);
    send_item(tcw_pkg::MODE_SET_CURSOR, 8'h00, 7'd127, 5'd31);
    send_item(tcw_pkg::MODE_SET_CURSOR, 8'h00, 7'd5, 5'd3);
    send_item(tcw_pkg::MODE_READ_CELL, 8'h00, 7'd79, 5'd24);
    send_item(tcw_pkg::MODE_PUT_CHAR, 8'h41, 7'd0, 5'd0);
    send_item(tcw_pkg::MODE_READ_CELL, 8'h00, 7'd5, 5'd3);
    send_item(tcw_pkg::MODE_WRITE_CELL, tcw_pkg::MARK_CHAR, 7'd127, 5'd31);
    send_item(tcw_pkg::MODE_WRITE_CELL, 8'hA5, 7'd0, 5'd0);
    send_item(tcw_pkg::MODE_CLEAR, 8'h00, 7'd0, 5'd0);
    send_item(tcw_pkg::MODE_READ_CELL, 8'h00, 7'd0, 5'd0);
    // newline, ordinary byte and tab each running off the bottom row
    send_item(tcw_pkg::MODE_SET_CURSOR, 8'h00, 7'd0, 5'd24);
    send_item(tcw_pkg::MODE_PUT_CHAR, tcw_pkg::CHAR_LF, 7'd0, 5'd0);
    send_item(tcw_pkg::MODE_SET_CURSOR, 8'h00, 7'd79, 5'd24);
    send_item(tcw_pkg::MODE_PUT_CHAR, 8'h42, 7'd0, 5'd0);
    send_item(tcw_pkg::MODE_SET_CURSOR, 8'h00, 7'd79, 5'd24);
    send_item(tcw_pkg::MODE_PUT_CHAR, tcw_pkg::CHAR_TAB, 7'd0, 5'd0);
    send_item(tcw_pkg::MODE_READ_CELL, 8'h00, 7'd79, 5'd23);
    for (int m = MODE_SPARE_LO; m <= MODE_SPARE_HI; m++)
      send_item(tcw_pkg::MODE_W'(m), 8'h5A, 7'd3, 5'd2);
    drain(1'b1);

    for (int p = 0; p < PHASES; p++) begin
      case (p / 2)
        0: begin
          send_idle_pct = 18;
          recv_idle_pct = 78;
        end
        1: begin
          send_idle_pct = 78;
          recv_idle_pct = 18;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      case (p)
        0:       write_regs(1'b1, 8'hFF);
        1:       write_regs(1'b0, 8'h00);
        2:       write_regs(1'b1, 8'h00);
        3:       write_regs(1'b0, tcw_pkg::BYTE_W'($urandom_range(0, 255)));
        4:       write_regs(1'b1, tcw_pkg::BYTE_W'($urandom_range(0, 255)));
        default: write_regs(1'b1, 8'd7);
      endcase
      repeat (PHASE_ITEMS) begin
        send_random_item();
        if ($urandom_range(0, 149) == 0) drain(1'b0);
      end
      drain(1'b1);
    end

    if (sb.mismatches == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
